/* sv/fcik_pkg.sv */
// Package for the follow-chain IK step block: widths, constants, FSM states and a saturation function.
// Used by every file of the block; depends on nothing.
package fcik_pkg;
  localparam int NUM_JOINTS = 10;
  localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int COORD_W = 24;
  localparam int LEN_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_IDX_W = 6;
  localparam int DIFF_W = 26;
  localparam int MAG_W = 25;
  localparam int D2_W = 51;
  localparam int ROOT_W = 26;
  localparam int PROD_W = MAG_W + LEN_W;
  localparam int QUO_W = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 2'd2;

  localparam logic [LEN_W-1:0] SEG_LEN_RST = 20'd12800;
  localparam logic signed [COORD_W-1:0] ANCHOR_X_RST = 24'sd204800;
  localparam logic signed [COORD_W-1:0] ANCHOR_Y_RST = 24'sd115200;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RDNEXT, ST_RDCUR, ST_DIFF, ST_SQX, ST_SQY, ST_CMP,
    ST_ROOT, ST_MULX, ST_DIVX, ST_MULY, ST_DIVY, ST_WRITE, ST_EMIT
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (v > hi) return 24'sh7fffff;
    else if (v < lo) return 24'sh800000;
    else return v[COORD_W-1:0];
  endfunction
endpackage

/* sv/fcik_if.sv */
// Valid/ready channel interfaces for the follow-chain IK step block.
// Depends on fcik_pkg.
interface fcik_in_if;
  logic valid;
  logic ready;
  logic signed [fcik_pkg::COORD_W-1:0] target_x;
  logic signed [fcik_pkg::COORD_W-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

interface fcik_out_if;
  logic valid;
  logic ready;
  logic [fcik_pkg::OUT_IDX_W-1:0] joint_index;
  logic signed [fcik_pkg::COORD_W-1:0] joint_x;
  logic signed [fcik_pkg::COORD_W-1:0] joint_y;
  logic last_joint;
  modport source (output valid, joint_index, joint_x, joint_y, last_joint, input ready);
  modport sink (input valid, joint_index, joint_x, joint_y, last_joint, output ready);
endinterface

/* sv/fcik_ram.sv */
// Joint position store: one write port, one read port, registered read data.
// Depends on fcik_pkg.
module fcik_ram (
  input  logic                                clk,
  input  logic                                we,
  input  logic [fcik_pkg::IDX_W-1:0]          waddr,
  input  logic [2*fcik_pkg::COORD_W-1:0]      wdata,
  input  logic [fcik_pkg::IDX_W-1:0]          raddr,
  output logic [2*fcik_pkg::COORD_W-1:0]      rdata
);
  logic [2*fcik_pkg::COORD_W-1:0] mem [fcik_pkg::NUM_JOINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/fcik_sqrt.sv */
// Bit-serial integer square root: each step shifts in two radicand bits and yields one result bit.
// Depends on fcik_pkg.
module fcik_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fcik_pkg::D2_W-1:0]     radicand,
  output logic                          done,
  output logic [fcik_pkg::ROOT_W-1:0]   root
);
  localparam int RAD_W = 2 * fcik_pkg::ROOT_W;
  localparam int CNT_W = $clog2(fcik_pkg::ROOT_W + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [fcik_pkg::ROOT_W+1:0] rem_r, rem_nxt;
  logic [fcik_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [fcik_pkg::ROOT_W+1:0] trial;
  logic [fcik_pkg::ROOT_W+1:0] shifted;

  always_comb begin
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    shifted = {rem_r[fcik_pkg::ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial = {root_r, 2'b01};
    if (start) begin
      rad_nxt = {1'b0, radicand};
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = CNT_W'(fcik_pkg::ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        root_nxt = {root_r[fcik_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        root_nxt = {root_r[fcik_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign root = root_nxt;
endmodule

/* sv/fcik_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fcik_pkg.
module fcik_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fcik_pkg::QUO_W-1:0]    dividend,
  input  logic [fcik_pkg::ROOT_W-1:0]   divisor,
  output logic                          done,
  output logic [fcik_pkg::QUO_W-1:0]    quotient
);
  localparam int CNT_W = $clog2(fcik_pkg::QUO_W + 1);

  logic [fcik_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [fcik_pkg::ROOT_W:0] rem_r, rem_nxt;
  logic [fcik_pkg::ROOT_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [fcik_pkg::ROOT_W:0] shifted;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    shifted = {rem_r[fcik_pkg::ROOT_W-1:0], quo_r[fcik_pkg::QUO_W-1]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(fcik_pkg::QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[fcik_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[fcik_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quotient = quo_nxt;
endmodule

/* sv/follow_chain_ik_step.sv */
// Follow-chain IK step: one backward pass over a stored 2-D joint chain per item.
// Each of the nine joints below the tip either stays put or is pulled, which takes a square root and
// two divides; then the base is read and the results are emitted. A further item is taken only
// once all results have left. Reset is sync, active low; a clearing pass then writes the reset
// chain.
module follow_chain_ik_step (
  input  logic                                   clk,
  input  logic                                   rst_n,
  fcik_in_if.sink                                in_ch,
  fcik_out_if.source                             out_ch,
  input  logic                                   cfg_we,
  input  logic [fcik_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fcik_pkg::COORD_W-1:0]           cfg_data
);
  localparam int IW = fcik_pkg::IDX_W;
  localparam int CW = fcik_pkg::COORD_W;
  localparam logic [IW-1:0] TIP = IW'(fcik_pkg::NUM_JOINTS - 1);

  fcik_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [fcik_pkg::LEN_W-1:0] seg_len_r;
  logic signed [CW-1:0] anchor_x_r, anchor_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= fcik_pkg::SEG_LEN_RST;
      anchor_x_r <= fcik_pkg::ANCHOR_X_RST;
      anchor_y_r <= fcik_pkg::ANCHOR_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcik_pkg::REG_SEG_LEN: seg_len_r <= cfg_data[fcik_pkg::LEN_W-1:0];
        fcik_pkg::REG_ANCHOR_X: anchor_x_r <= cfg_data;
        fcik_pkg::REG_ANCHOR_Y: anchor_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers. idx_r is the joint being walked or emitted; init_y_r tracks the
  // reset y position during the clearing pass.
  logic [IW-1:0] idx_r, idx_nxt;
  logic signed [CW+1:0] init_y_r, init_y_nxt;
  logic signed [CW-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [fcik_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [fcik_pkg::D2_W-1:0] d2_r, d2_nxt;
  logic [fcik_pkg::ROOT_W-1:0] dist_r, dist_nxt;
  logic [fcik_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [CW-1:0] newx_r, newx_nxt;
  logic [fcik_pkg::MAG_W-1:0] ax, ay, amag;
  logic [2*fcik_pkg::MAG_W-1:0] sq;
  logic [2*fcik_pkg::LEN_W-1:0] len2;
  logic signed [CW+1:0] sum;
  logic signed [CW+1:0] offs;

  // Memory port signals.
  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;

  // Shared root and divider units.
  logic sq_start, sq_done, dv_start, dv_done;
  logic dv_go_r;
  logic [fcik_pkg::ROOT_W-1:0] sq_root;
  logic [fcik_pkg::QUO_W-1:0] dv_quo;
  logic [fcik_pkg::QUO_W-1:0] dv_dividend;

  fcik_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  fcik_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(d2_r),
    .done(sq_done), .root(sq_root)
  );

  fcik_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go_r), .dividend(dv_dividend),
    .divisor(dist_r), .done(dv_done), .quotient(dv_quo)
  );

  assign ax = dx_r[fcik_pkg::DIFF_W-1] ? fcik_pkg::MAG_W'(-dx_r) : fcik_pkg::MAG_W'(dx_r);
  assign ay = dy_r[fcik_pkg::DIFF_W-1] ? fcik_pkg::MAG_W'(-dy_r) : fcik_pkg::MAG_W'(dy_r);
  assign len2 = seg_len_r * seg_len_r;
  // Rounded divide: (|d| * L + dist / 2) / dist.
  assign dv_dividend = fcik_pkg::QUO_W'(prod_r) + fcik_pkg::QUO_W'(dist_r >> 1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    init_y_nxt = init_y_r;
    nx_nxt = nx_r; ny_nxt = ny_r;
    cx_nxt = cx_r; cy_nxt = cy_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    d2_nxt = d2_r;
    dist_nxt = dist_r;
    prod_nxt = prod_r;
    newx_nxt = newx_r;
    ram_we = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {cx_r, cy_r};
    ram_raddr = idx_r;
    sq_start = 1'b0;
    dv_start = 1'b0;
    in_ch.ready = 1'b0;
    sq = '0;
    amag = '0;
    sum = '0;
    offs = '0;
    unique case (state_r)
      fcik_pkg::ST_INIT: begin
        ram_we = 1'b1;
        ram_wdata = {anchor_x_r, fcik_pkg::sat24(init_y_r)};
        init_y_nxt = (CW+2)'(fcik_pkg::sat24(init_y_r)) + (CW+2)'(seg_len_r);
        idx_nxt = idx_r + 1'b1;
        if (idx_r == TIP) begin
          state_nxt = fcik_pkg::ST_IDLE;
          idx_nxt = '0;
        end
      end
      fcik_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          // The tip takes the target; the walk starts at the joint below it.
          ram_we = 1'b1;
          ram_waddr = TIP;
          ram_wdata = {in_ch.target_x, in_ch.target_y};
          nx_nxt = in_ch.target_x;
          ny_nxt = in_ch.target_y;
          idx_nxt = TIP - 1'b1;
          state_nxt = fcik_pkg::ST_RDCUR;
        end
      end
      fcik_pkg::ST_RDNEXT: begin
        // The successor is the joint just written back, already held in cx/cy.
        nx_nxt = cx_r;
        ny_nxt = cy_r;
        state_nxt = fcik_pkg::ST_RDCUR;
      end
      fcik_pkg::ST_RDCUR: begin
        state_nxt = fcik_pkg::ST_DIFF;
      end
      fcik_pkg::ST_DIFF: begin
        cx_nxt = ram_rdata[2*CW-1:CW];
        cy_nxt = ram_rdata[CW-1:0];
        dx_nxt = fcik_pkg::DIFF_W'($signed(ram_rdata[2*CW-1:CW])) - fcik_pkg::DIFF_W'(nx_r);
        dy_nxt = fcik_pkg::DIFF_W'($signed(ram_rdata[CW-1:0])) - fcik_pkg::DIFF_W'(ny_r);
        state_nxt = fcik_pkg::ST_SQX;
      end
      fcik_pkg::ST_SQX: begin
        sq = ax * ax;
        d2_nxt = fcik_pkg::D2_W'(sq);
        state_nxt = fcik_pkg::ST_SQY;
      end
      fcik_pkg::ST_SQY: begin
        sq = ay * ay;
        d2_nxt = d2_r + fcik_pkg::D2_W'(sq);
        state_nxt = fcik_pkg::ST_CMP;
      end
      fcik_pkg::ST_CMP: begin
        if (d2_r > fcik_pkg::D2_W'(len2)) begin
          sq_start = 1'b1;
          state_nxt = fcik_pkg::ST_ROOT;
        end else begin
          state_nxt = fcik_pkg::ST_WRITE;
        end
      end
      fcik_pkg::ST_ROOT: begin
        if (sq_done) begin
          dist_nxt = sq_root;
          state_nxt = fcik_pkg::ST_MULX;
        end
      end
      fcik_pkg::ST_MULX: begin
        prod_nxt = ax * seg_len_r;
        dv_start = 1'b0;
        state_nxt = fcik_pkg::ST_DIVX;
        // Divide starts next cycle from the registered product.
      end
      fcik_pkg::ST_DIVX: begin
        if (dv_done) begin
          offs = dx_r[fcik_pkg::DIFF_W-1] ? -(CW+2)'(dv_quo) : (CW+2)'(dv_quo);
          sum = (CW+2)'(nx_r) + offs;
          newx_nxt = fcik_pkg::sat24(sum);
          state_nxt = fcik_pkg::ST_MULY;
        end
      end
      fcik_pkg::ST_MULY: begin
        amag = ay;
        prod_nxt = amag * seg_len_r;
        state_nxt = fcik_pkg::ST_DIVY;
      end
      fcik_pkg::ST_DIVY: begin
        if (dv_done) begin
          offs = dy_r[fcik_pkg::DIFF_W-1] ? -(CW+2)'(dv_quo) : (CW+2)'(dv_quo);
          sum = (CW+2)'(ny_r) + offs;
          cx_nxt = newx_r;
          cy_nxt = fcik_pkg::sat24(sum);
          state_nxt = fcik_pkg::ST_WRITE;
        end
      end
      fcik_pkg::ST_WRITE: begin
        ram_we = 1'b1;
        if (idx_r == '0) begin
          // The base snaps to the anchor; emission then starts at joint zero.
          ram_wdata = {anchor_x_r, anchor_y_r};
          ram_raddr = '0;
          state_nxt = fcik_pkg::ST_EMIT;
        end else begin
          idx_nxt = idx_r - 1'b1;
          ram_raddr = idx_r - 1'b1;
          state_nxt = fcik_pkg::ST_RDNEXT;
        end
      end
      fcik_pkg::ST_EMIT: begin
        // The address only moves on once the current joint has been taken, so the read
        // data stays put while the receiver holds off.
        ram_raddr = idx_r;
        if (out_ch.valid && out_ch.ready) begin
          if (idx_r == TIP) begin
            idx_nxt = '0;
            state_nxt = fcik_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            ram_raddr = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = fcik_pkg::ST_IDLE;
    endcase
    // Raise the divider start in either multiply state; it reaches the divider through dv_go_r.
    if (state_r == fcik_pkg::ST_MULX || state_r == fcik_pkg::ST_MULY) begin
      dv_start = 1'b1;
    end
  end

  // The divider takes its dividend from prod_r, which holds the product only from the cycle
  // after the multiply, so the start is delayed by one register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_go_r <= 1'b0;
    end else begin
      dv_go_r <= dv_start;
    end
  end

  // Emission: the base is written in the cycle that enters emission, so its read is issued on
  // entry to emission and results are offered once the read data and emit_ok_r are registered.
  logic emit_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_ok_r <= 1'b0;
    end else begin
      emit_ok_r <= (state_r == fcik_pkg::ST_EMIT) && (state_nxt == fcik_pkg::ST_EMIT);
    end
  end

  assign out_ch.valid = (state_r == fcik_pkg::ST_EMIT) && emit_ok_r;
  assign out_ch.joint_index = fcik_pkg::OUT_IDX_W'(idx_r);
  assign out_ch.joint_x = ram_rdata[2*CW-1:CW];
  assign out_ch.joint_y = ram_rdata[CW-1:0];
  assign out_ch.last_joint = (idx_r == TIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcik_pkg::ST_INIT;
      idx_r <= '0;
      init_y_r <= (CW+2)'(fcik_pkg::ANCHOR_Y_RST);
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      init_y_r <= init_y_nxt;
    end
    nx_r <= nx_nxt; ny_r <= ny_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt;
    d2_r <= d2_nxt;
    dist_r <= dist_nxt;
    prod_r <= prod_nxt;
    newx_r <= newx_nxt;
  end

`ifndef SYNTHESIS
  // Results appear only during the emission phase.
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> state_r == fcik_pkg::ST_EMIT)
    else $error("result offered outside emission");
  // No new item is taken while the walk or emission is under way.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == fcik_pkg::ST_IDLE)
    else $error("item accepted while busy");
  // A completed last result returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_joint) |=> state_r == fcik_pkg::ST_IDLE)
    else $error("no return to idle after last result");
`endif
endmodule
